// ===== hw/rtl/ftc_pkg.sv =====
// ----------------------------------------------------------------------------
// ftc_pkg
// shared widths, register codes and reset values of the floor texture caster
// ----------------------------------------------------------------------------
package ftc_pkg;

  // texture geometry defaults
  localparam int TEX_WIDTH_DEF  = 64;
  localparam int TEX_HEIGHT_DEF = 64;

  // texture store
  localparam int STORE_DEPTH = 4096;
  localparam int STORE_AW    = 12;
  localparam int COLOR_W     = 24;

  // item fields
  localparam int COORD_W = 11;
  localparam int DIM_W   = 12;
  localparam int POS_W   = 24;
  localparam int VEC_W   = 16;
  localparam int ADDR_W  = 22;

  // stream payloads
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 48;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_WIDTH  = 3'd0,
    REG_SCREEN_HEIGHT = 3'd1,
    REG_CAM_POS_X     = 3'd2,
    REG_CAM_POS_Y     = 3'd3,
    REG_VIEW_DIR_X    = 3'd4,
    REG_VIEW_DIR_Y    = 3'd5,
    REG_CAM_PLANE_X   = 3'd6,
    REG_CAM_PLANE_Y   = 3'd7
  } cfg_reg_t;

  // item kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_SHADE = 1'b1;

  // register reset values
  localparam logic [DIM_W-1:0] SCREEN_WIDTH_RST  = 12'd640;
  localparam logic [DIM_W-1:0] SCREEN_HEIGHT_RST = 12'd480;
  localparam logic [VEC_W-1:0] VIEW_DIR_X_RST    = 16'd16384;
  localparam logic [VEC_W-1:0] CAM_PLANE_Y_RST   = 16'd10813;

endpackage

// ===== hw/rtl/ftc_ram.sv =====
// ----------------------------------------------------------------------------
// ftc_ram
// simple dual-port ram, one write port, one read port with registered data
// ----------------------------------------------------------------------------
module ftc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/floor_texture_caster_unit.sv =====
// ----------------------------------------------------------------------------
// floor_texture_caster_unit
// perspective floor texturing, one screen pixel per shade item
// ----------------------------------------------------------------------------
// usage
//   s_* stream carries items in: s_tuser is the kind (0 load texel, 1 shade
//   pixel); a load writes texel_color into the texture store at texel_index
//   and gives no result, a shade item gives one result on the m_* stream
//   m_tdata holds pixel_address and pixel_color, m_tuser flags the horizon
//   row (color forced to zero there)
//   cfg_* writes one camera or screen register per handshake; cfg_ready is
//   always high, registers must only change while no item is in flight
// throughput: one item per clock, sustained while m_tready does not hold the pipe
// depth: the pipe depth is set by the 27 stage row distance divider and
//   the 39 stage divider by the screen width, one quotient bit per stage
// loads travel the whole pipe and write the store at the same stage where
//   shades read it, so item order is kept
// reset: clears all valid bits and loads the register reset values; the
//   texture store is not cleared and must be loaded before use
// stall: while m_tvalid is high and m_tready low the whole pipe holds,
//   s_tready drops in the same cycle; nothing is lost or repeated
// ----------------------------------------------------------------------------
module floor_texture_caster_unit
  import ftc_pkg::*;
#(
  parameter int TEX_WIDTH  = TEX_WIDTH_DEF,
  parameter int TEX_HEIGHT = TEX_HEIGHT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // in: column[10:0] row[21:11] texel_index[33:22] texel_color[57:34], zero pad
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // in: kind
  input  logic                  s_tuser,
  // out: pixel_address[21:0] pixel_color[45:22], zero pad
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  // out: horizon
  output logic                  m_tuser,
  // register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // --------------------------------------------------------------------------
  // widths of the datapath
  // --------------------------------------------------------------------------
  localparam int PW_W    = 30;            // ray0 * width
  localparam int PC_W    = 29;            // column * 2 * plane
  localparam int R_W     = 31;            // ray numerator, signed
  localparam int RM_W    = 29;            // its magnitude
  localparam int DQ      = 27;            // bits of (height << 15) / p
  localparam int DM_W    = 25;            // saturated distance magnitude
  localparam int LO_W    = 15;            // low slice of |r|
  localparam int HI_W    = RM_W - LO_W;
  localparam int PL_W    = DM_W + LO_W;
  localparam int PH_W    = DM_W + HI_W;
  localparam int PROD_W  = DM_W + RM_W - 1;
  localparam int SHIFT   = 14;            // Q2.14 scale of the ray
  localparam int NUM_W   = PROD_W - SHIFT;
  localparam int FRAC_W  = 16;
  localparam int PMAG_W  = COORD_W;
  localparam int TX_W    = $clog2(TEX_WIDTH);
  localparam int TY_W    = $clog2(TEX_HEIGHT);
  localparam int TWM_W   = $clog2(TEX_WIDTH + 1);
  localparam int THM_W   = $clog2(TEX_HEIGHT + 1);
  localparam int FXP_W   = FRAC_W + TWM_W;
  localparam int FYP_W   = FRAC_W + THM_W;
  localparam int ENT_W   = TY_W + TWM_W + 1;
  localparam int SUM_W   = (ENT_W > STORE_AW) ? ENT_W : STORE_AW;

  localparam logic [DQ-1:0] DIST_NEG_LIM = DQ'(1) << 24;
  localparam logic [DQ-1:0] DIST_POS_LIM = DIST_NEG_LIM - DQ'(1);

  // --------------------------------------------------------------------------
  // stage records
  // --------------------------------------------------------------------------
  typedef struct packed {
    logic                valid;
    logic                kind;
    logic [COORD_W-1:0]  col;
    logic [COORD_W-1:0]  row;
    logic [STORE_AW-1:0] tidx;
    logic [COLOR_W-1:0]  tcolor;
  } front_t;

  // what every later stage carries along
  typedef struct packed {
    logic                valid;
    logic                kind;
    logic                horizon;
    logic [ADDR_W-1:0]   addr;
    logic [STORE_AW-1:0] tidx;
    logic [COLOR_W-1:0]  tcolor;
  } ctl_t;

  typedef struct packed {
    ctl_t                  ctl;
    logic                  p_neg;
    logic [PMAG_W-1:0]     p_mag;
    logic [1:0][PW_W-1:0]  pw;
    logic [1:0][PC_W-1:0]  pc;
  } s2_t;

  typedef struct packed {
    ctl_t                 ctl;
    logic                 p_neg;
    logic [PMAG_W-1:0]    p_mag;
    logic [1:0][R_W-1:0]  r;
    logic [PMAG_W-1:0]    rem;
    logic [DQ-1:0]        quo;
  } dv_t;

  typedef struct packed {
    ctl_t                  ctl;
    logic [1:0]            sgn;
    logic [DM_W-1:0]       dmag;
    logic [1:0][RM_W-1:0]  rmag;
  } dm_t;

  typedef struct packed {
    ctl_t                  ctl;
    logic [1:0]            sgn;
    logic [1:0][PL_W-1:0]  lo;
    logic [1:0][PH_W-1:0]  hi;
  } m1_t;

  typedef struct packed {
    ctl_t                    ctl;
    logic [1:0]              sgn;
    logic [1:0]              sticky;
    logic [1:0][NUM_W-1:0]   num;
    logic [1:0][DIM_W-1:0]   rem;
    logic [1:0][FRAC_W-1:0]  q;
  } wv_t;

  typedef struct packed {
    ctl_t                    ctl;
    logic [1:0][FRAC_W-1:0]  frac;
  } f1_t;

  typedef struct packed {
    ctl_t             ctl;
    logic [TX_W-1:0]  tx;
    logic [TY_W-1:0]  ty;
  } f2_t;

  typedef struct packed {
    ctl_t                ctl;
    logic [STORE_AW-1:0] entry;
  } f3_t;

  typedef struct packed {
    logic              valid;
    logic              horizon;
    logic [ADDR_W-1:0] addr;
  } out_t;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [DIM_W-1:0] screen_width;
  logic [DIM_W-1:0] screen_height;
  logic [POS_W-1:0] cam_pos_x;
  logic [POS_W-1:0] cam_pos_y;
  logic [VEC_W-1:0] view_dir_x;
  logic [VEC_W-1:0] view_dir_y;
  logic [VEC_W-1:0] cam_plane_x;
  logic [VEC_W-1:0] cam_plane_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= SCREEN_WIDTH_RST;
      screen_height <= SCREEN_HEIGHT_RST;
      cam_pos_x     <= '0;
      cam_pos_y     <= '0;
      view_dir_x    <= VIEW_DIR_X_RST;
      view_dir_y    <= '0;
      cam_plane_x   <= '0;
      cam_plane_y   <= CAM_PLANE_Y_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_SCREEN_WIDTH:  screen_width  <= cfg_data[DIM_W-1:0];
        REG_SCREEN_HEIGHT: screen_height <= cfg_data[DIM_W-1:0];
        REG_CAM_POS_X:     cam_pos_x     <= cfg_data[POS_W-1:0];
        REG_CAM_POS_Y:     cam_pos_y     <= cfg_data[POS_W-1:0];
        REG_VIEW_DIR_X:    view_dir_x    <= cfg_data[VEC_W-1:0];
        REG_VIEW_DIR_Y:    view_dir_y    <= cfg_data[VEC_W-1:0];
        REG_CAM_PLANE_X:   cam_plane_x   <= cfg_data[VEC_W-1:0];
        REG_CAM_PLANE_Y:   cam_plane_y   <= cfg_data[VEC_W-1:0];
        default: ;
      endcase
    end
  end

  // derived camera values, x in slot 0 and y in slot 1
  logic [DIM_W-1:0]         w_eff;
  logic [DQ-1:0]            n_dist;
  logic [FRAC_W-1:0]        pos_lo [2];
  logic signed [VEC_W:0]    ray0   [2];
  logic signed [VEC_W:0]    plane2 [2];

  always_comb begin
    // a zero width behaves as a width of one
    w_eff     = (screen_width == '0) ? DIM_W'(1) : screen_width;
    // row distance numerator: (height / 2) in Q11.16
    n_dist    = {screen_height, 15'b0};
    pos_lo[0] = cam_pos_x[FRAC_W-1:0];
    pos_lo[1] = cam_pos_y[FRAC_W-1:0];
    ray0[0]   = (VEC_W+1)'($signed(view_dir_x)) - (VEC_W+1)'($signed(cam_plane_x));
    ray0[1]   = (VEC_W+1)'($signed(view_dir_y)) - (VEC_W+1)'($signed(cam_plane_y));
    // ray1 - ray0 is twice the plane
    plane2[0] = $signed({cam_plane_x, 1'b0});
    plane2[1] = $signed({cam_plane_y, 1'b0});
  end

  // --------------------------------------------------------------------------
  // pipeline advance: every stage moves together unless the result waits
  // --------------------------------------------------------------------------
  out_t o_q;
  logic en;

  assign en       = !o_q.valid || m_tready;
  assign s_tready = en;

  // stage 1: input register
  front_t s1_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_q.valid <= 1'b0;
    end else if (en) begin
      s1_q.valid  <= s_tvalid;
      s1_q.kind   <= s_tuser;
      s1_q.col    <= s_tdata[COORD_W-1:0];
      s1_q.row    <= s_tdata[2*COORD_W-1:COORD_W];
      s1_q.tidx   <= s_tdata[2*COORD_W+STORE_AW-1:2*COORD_W];
      s1_q.tcolor <= s_tdata[2*COORD_W+STORE_AW+COLOR_W-1:2*COORD_W+STORE_AW];
    end
  end

  // stage 2: row offset from the horizon, address, the four ray products
  s2_t s2_d, s2_q;

  always_comb begin
    logic signed [DIM_W-1:0] p;
    logic [ADDR_W+1:0]       addr_full;
    logic signed [PW_W-1:0]  pw_s;
    logic signed [PC_W-1:0]  pc_s;
    p = $signed({1'b0, s1_q.row}) - $signed({1'b0, screen_height[DIM_W-1:1]});
    addr_full = (ADDR_W+2)'(s1_q.row) * (ADDR_W+2)'(w_eff) + (ADDR_W+2)'(s1_q.col);
    s2_d.ctl.valid   = s1_q.valid;
    s2_d.ctl.kind    = s1_q.kind;
    s2_d.ctl.horizon = (p == '0);
    s2_d.ctl.addr    = addr_full[ADDR_W-1:0];
    s2_d.ctl.tidx    = s1_q.tidx;
    s2_d.ctl.tcolor  = s1_q.tcolor;
    s2_d.p_neg       = p[DIM_W-1];
    s2_d.p_mag       = p[DIM_W-1] ? PMAG_W'(-p) : p[PMAG_W-1:0];
    for (int a = 0; a < 2; a++) begin
      pw_s = PW_W'(ray0[a]) * PW_W'($signed({1'b0, w_eff}));
      pc_s = PC_W'($signed({1'b0, s1_q.col})) * PC_W'(plane2[a]);
      s2_d.pw[a] = pw_s;
      s2_d.pc[a] = pc_s;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_q.ctl.valid <= 1'b0;
    end else if (en) begin
      s2_q <= s2_d;
    end
  end

  // --------------------------------------------------------------------------
  // row distance divider: (height << 15) / |p|, one quotient bit a stage
  // --------------------------------------------------------------------------
  function automatic dv_t dist_step(dv_t d, logic nbit);
    dv_t              res;
    logic [PMAG_W:0]  rem_sh;
    logic [PMAG_W:0]  dvsr;
    logic             ge;
    res    = d;
    rem_sh = {d.rem, nbit};
    dvsr   = {1'b0, d.p_mag};
    ge     = (rem_sh >= dvsr);
    res.rem = ge ? PMAG_W'(rem_sh - dvsr) : rem_sh[PMAG_W-1:0];
    res.quo = {d.quo[DQ-2:0], ge};
    return res;
  endfunction

  dv_t dv_in [DQ];
  dv_t dv_q  [DQ];

  // first step also sums the ray numerator
  always_comb begin
    dv_in[0].ctl   = s2_q.ctl;
    dv_in[0].p_neg = s2_q.p_neg;
    dv_in[0].p_mag = s2_q.p_mag;
    for (int a = 0; a < 2; a++) begin
      dv_in[0].r[a] = R_W'($signed(s2_q.pw[a])) + R_W'($signed(s2_q.pc[a]));
    end
    dv_in[0].rem = '0;
    dv_in[0].quo = '0;
  end

  for (genvar k = 0; k < DQ; k++) begin : g_dist
    if (k > 0) begin : g_link
      assign dv_in[k] = dv_q[k-1];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_q[k].ctl.valid <= 1'b0;
      end else if (en) begin
        dv_q[k] <= dist_step(dv_in[k], n_dist[DQ-1-k]);
      end
    end
  end

  // saturate the distance, split the ray numerator into sign and magnitude
  dm_t dm_d, dm_q;

  always_comb begin
    logic [DQ-1:0]  q;
    logic [R_W-1:0] r_abs;
    q = dv_q[DQ-1].quo;
    dm_d.ctl = dv_q[DQ-1].ctl;
    if (dv_q[DQ-1].p_neg) begin
      dm_d.dmag = (q > DIST_NEG_LIM) ? DM_W'(DIST_NEG_LIM) : DM_W'(q);
    end else begin
      dm_d.dmag = (q > DIST_POS_LIM) ? DM_W'(DIST_POS_LIM) : DM_W'(q);
    end
    for (int a = 0; a < 2; a++) begin
      r_abs = dv_q[DQ-1].r[a][R_W-1] ? (-dv_q[DQ-1].r[a]) : dv_q[DQ-1].r[a];
      dm_d.rmag[a] = r_abs[RM_W-1:0];
      dm_d.sgn[a]  = dv_q[DQ-1].p_neg ^ dv_q[DQ-1].r[a][R_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dm_q.ctl.valid <= 1'b0;
    end else if (en) begin
      dm_q <= dm_d;
    end
  end

  // distance times ray, as two partial products per axis
  m1_t m1_d, m1_q;

  always_comb begin
    m1_d.ctl = dm_q.ctl;
    m1_d.sgn = dm_q.sgn;
    for (int a = 0; a < 2; a++) begin
      m1_d.lo[a] = PL_W'(dm_q.dmag) * PL_W'(dm_q.rmag[a][LO_W-1:0]);
      m1_d.hi[a] = PH_W'(dm_q.dmag) * PH_W'(dm_q.rmag[a][RM_W-1:LO_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_q.ctl.valid <= 1'b0;
    end else if (en) begin
      m1_q <= m1_d;
    end
  end

  // join the partial products, drop the Q2.14 scale and keep a sticky bit
  wv_t m2_d, m2_q;

  always_comb begin
    logic [PROD_W-1:0] prod;
    m2_d.ctl = m1_q.ctl;
    m2_d.sgn = m1_q.sgn;
    for (int a = 0; a < 2; a++) begin
      prod = (PROD_W'(m1_q.hi[a]) << LO_W) + PROD_W'(m1_q.lo[a]);
      m2_d.num[a]    = prod[PROD_W-1:SHIFT];
      m2_d.sticky[a] = |prod[SHIFT-1:0];
      m2_d.rem[a]    = '0;
      m2_d.q[a]      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_q.ctl.valid <= 1'b0;
    end else if (en) begin
      m2_q <= m2_d;
    end
  end

  // --------------------------------------------------------------------------
  // width divider: |dist * r| >> 14 by width, both axes side by side;
  // only the low 16 quotient bits are kept, they carry the floor fraction
  // --------------------------------------------------------------------------
  function automatic wv_t width_step(wv_t d, logic [DIM_W-1:0] w);
    wv_t             res;
    logic [DIM_W:0]  rem_sh;
    logic [DIM_W:0]  dvsr;
    logic            ge;
    res  = d;
    dvsr = {1'b0, w};
    for (int a = 0; a < 2; a++) begin
      rem_sh = {d.rem[a], d.num[a][NUM_W-1]};
      ge     = (rem_sh >= dvsr);
      res.rem[a] = ge ? DIM_W'(rem_sh - dvsr) : rem_sh[DIM_W-1:0];
      res.q[a]   = {d.q[a][FRAC_W-2:0], ge};
      res.num[a] = {d.num[a][NUM_W-2:0], 1'b0};
    end
    return res;
  endfunction

  wv_t wv_in [NUM_W];
  wv_t wv_q  [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_width
    if (k == 0) begin : g_head
      assign wv_in[k] = m2_q;
    end else begin : g_link
      assign wv_in[k] = wv_q[k-1];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        wv_q[k].ctl.valid <= 1'b0;
      end else if (en) begin
        wv_q[k] <= width_step(wv_in[k], w_eff);
      end
    end
  end

  // floor rounding of the offset, then the fractional floor position
  f1_t f1_d, f1_q;

  always_comb begin
    logic [FRAC_W-1:0] mag;
    logic [FRAC_W-1:0] off;
    logic              inexact;
    f1_d.ctl = wv_q[NUM_W-1].ctl;
    for (int a = 0; a < 2; a++) begin
      inexact = wv_q[NUM_W-1].sticky[a] || (wv_q[NUM_W-1].rem[a] != '0);
      // a negative quotient rounds toward minus infinity
      mag = wv_q[NUM_W-1].q[a] + FRAC_W'(inexact);
      off = wv_q[NUM_W-1].sgn[a] ? (-mag) : wv_q[NUM_W-1].q[a];
      f1_d.frac[a] = pos_lo[a] + off;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_q.ctl.valid <= 1'b0;
    end else if (en) begin
      f1_q <= f1_d;
    end
  end

  // texel coordinates
  f2_t f2_d, f2_q;

  always_comb begin
    logic [FXP_W-1:0] px;
    logic [FYP_W-1:0] py;
    px = FXP_W'(f1_q.frac[0]) * FXP_W'(TEX_WIDTH);
    py = FYP_W'(f1_q.frac[1]) * FYP_W'(TEX_HEIGHT);
    f2_d.ctl = f1_q.ctl;
    f2_d.tx  = TX_W'(px[FXP_W-1:FRAC_W]);
    f2_d.ty  = TY_W'(py[FYP_W-1:FRAC_W]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f2_q.ctl.valid <= 1'b0;
    end else if (en) begin
      f2_q <= f2_d;
    end
  end

  // store entry, wrapped to the store depth
  f3_t f3_d, f3_q;

  always_comb begin
    logic [SUM_W-1:0] ent;
    ent = SUM_W'(f2_q.ty) * SUM_W'(TEX_WIDTH) + SUM_W'(f2_q.tx);
    f3_d.ctl   = f2_q.ctl;
    f3_d.entry = ent[STORE_AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f3_q.ctl.valid <= 1'b0;
    end else if (en) begin
      f3_q <= f3_d;
    end
  end

  // --------------------------------------------------------------------------
  // texture store: loads write and shades read at the same stage
  // --------------------------------------------------------------------------
  logic               ram_we;
  logic               ram_re;
  logic [COLOR_W-1:0] ram_rdata;

  assign ram_we = en && f3_q.ctl.valid && (f3_q.ctl.kind == KIND_LOAD);
  assign ram_re = en && f3_q.ctl.valid && (f3_q.ctl.kind == KIND_SHADE);

  ftc_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (f3_q.ctl.tidx),
    .wdata (f3_q.ctl.tcolor),
    .re    (ram_re),
    .raddr (f3_q.entry),
    .rdata (ram_rdata)
  );

  // output register, lined up with the registered store read
  always_ff @(posedge clk) begin
    if (rst) begin
      o_q.valid <= 1'b0;
    end else if (en) begin
      o_q.valid   <= f3_q.ctl.valid && (f3_q.ctl.kind == KIND_SHADE);
      o_q.horizon <= f3_q.ctl.horizon;
      o_q.addr    <= f3_q.ctl.addr;
    end
  end

  // horizon row shows black
  assign m_tvalid = o_q.valid;
  assign m_tuser  = o_q.horizon;
  assign m_tdata  = {(OUT_DATA_W-ADDR_W-COLOR_W)'(0),
                     (o_q.horizon ? COLOR_W'(0) : ram_rdata),
                     o_q.addr};

endmodule

// ===== hw/rtl/ftc_checker.sv =====
// ----------------------------------------------------------------------------
// ftc_checker
// port level checks of the floor texture caster, bound to the top level
// ----------------------------------------------------------------------------
module ftc_checker
  import ftc_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic                  m_tuser
);

  // a waiting result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // and does not change
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // horizon pixels are black
  a_horizon_black: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[ADDR_W+COLOR_W-1:ADDR_W] == '0)
    else $error("horizon pixel with nonzero color");

  // input is taken whenever the output side can move
  a_accept: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid || m_tready |-> s_tready)
    else $error("input stalled with output free");

  // no result straight after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result offered after reset");

endmodule

bind floor_texture_caster_unit ftc_checker u_checker (.*);

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for floor_texture_caster_unit: texel loads and pixel
// shades are streamed in bursts, each result is checked against an in-bench
// perspective floor casting model, under random and long output stalls
// ----------------------------------------------------------------------------
module tb_top;
  import ftc_pkg::*;

  localparam int TEX_W      = TEX_WIDTH_DEF;
  localparam int TEX_H      = TEX_HEIGHT_DEF;
  localparam int PIPE_DEPTH = 75;
  localparam int SETTLE     = PIPE_DEPTH + 10;
  localparam int CYCLE_CAP  = 600000;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [COLOR_W-1:0] color;
    logic               horizon;
  } pixel_t;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata;
  logic s_tuser;
  logic m_tvalid;
  logic m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic m_tuser;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  floor_texture_caster_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // mirror of the camera and screen registers
  logic [DIM_W-1:0] scr_w, scr_h;
  logic [POS_W-1:0] pos_x, pos_y;
  logic [VEC_W-1:0] dir_x, dir_y, plane_x, plane_y;

  // mirror of the texture store and which entries hold a texel
  logic [COLOR_W-1:0] texels [STORE_DEPTH];
  bit                 texel_loaded [STORE_DEPTH];

  pixel_t pending_pixels [$];

  int errors;
  int cycles;
  int shades_sent, loads_sent, pixels_checked, horizons_seen;
  int burst_left;
  int stall_pct;
  int hold_req;

  // clock, 2 time units period
  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d pixels still pending", cycles,
               pending_pixels.size());
      $display("[floor_texture_caster_unit] ERROR");
      $finish;
    end
  end

  // output side: long hold when asked, otherwise a random stall rate
  always @(negedge clk) begin
    if (rst) begin
      m_tready = 1'b0;
    end else if (hold_req > 0) begin
      m_tready = 1'b0;
      hold_req = hold_req - 1;
    end else begin
      m_tready = ($urandom_range(99) >= stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    pixel_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected pixel addr %0h color %0h horizon %0b", $time,
                 m_tdata[ADDR_W-1:0], m_tdata[ADDR_W +: COLOR_W], m_tuser);
        errors++;
      end else begin
        want = pending_pixels.pop_front();
        pixels_checked++;
        if (m_tuser) horizons_seen++;
        if (m_tdata[ADDR_W-1:0] !== want.addr) begin
          $display("%0t: pixel_address expected %0h actual %0h", $time, want.addr,
                   m_tdata[ADDR_W-1:0]);
          errors++;
        end
        if (m_tdata[ADDR_W +: COLOR_W] !== want.color) begin
          $display("%0t: pixel_color expected %0h actual %0h", $time, want.color,
                   m_tdata[ADDR_W +: COLOR_W]);
          errors++;
        end
        if (m_tuser !== want.horizon) begin
          $display("%0t: horizon expected %0b actual %0b", $time, want.horizon, m_tuser);
          errors++;
        end
      end
    end
  end

  // floor point along one axis, mapped to a texel coordinate
  function automatic longint tex_axis(logic [POS_W-1:0] pos, longint rdist,
                                      logic [VEC_W-1:0] dir, logic [VEC_W-1:0] plane,
                                      longint col, longint w, longint size);
    longint ray0, r, num, den, off, f;
    ray0 = longint'($signed(dir)) - longint'($signed(plane));
    r    = ray0 * w + col * 2 * longint'($signed(plane));
    num  = rdist * r;
    den  = w <<< 14;
    off  = num / den;
    // floor rather than truncate for negative quotients
    if ((num % den) != 0 && num < 0) off = off - 1;
    f = (longint'(pos) + off) & 64'hFFFF;
    return (f * size) >>> 16;
  endfunction

  // texture entry hit by a pixel, -1 on the horizon row
  function automatic int floor_entry(int col, int row);
    longint w, p, rdist, tx, ty;
    w = (scr_w == 0) ? 1 : longint'(scr_w);
    p = longint'(row) - longint'(scr_h >> 1);
    if (p == 0) return -1;
    rdist = (longint'(scr_h) <<< 15) / p;
    if (rdist > 16777215) rdist = 16777215;
    if (rdist < -16777216) rdist = -16777216;
    tx = tex_axis(pos_x, rdist, dir_x, plane_x, col, w, TEX_W);
    ty = tex_axis(pos_y, rdist, dir_y, plane_y, col, w, TEX_H);
    return int'((ty * TEX_W + tx) & (STORE_DEPTH - 1));
  endfunction

  // hand one item to the block, honoring the burst and gap pattern
  task automatic push_item(logic kind, int col, int row, int idx, int color);
    if (burst_left == 0) begin
      s_tvalid = 1'b0;
      if ($urandom_range(3) != 0) repeat ($urandom_range(12)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_tuser  = kind;
    s_tdata  = '0;
    s_tdata[COORD_W-1:0]           = col[COORD_W-1:0];
    s_tdata[COORD_W +: COORD_W]    = row[COORD_W-1:0];
    s_tdata[2*COORD_W +: STORE_AW] = idx[STORE_AW-1:0];
    s_tdata[2*COORD_W+STORE_AW +: COLOR_W] = color[COLOR_W-1:0];
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic load_texel(int idx, int color);
    idx   = idx & (STORE_DEPTH - 1);
    color = color & 24'hFFFFFF;
    push_item(KIND_LOAD, 0, 0, idx, color);
    texels[idx] = color[COLOR_W-1:0];
    texel_loaded[idx] = 1'b1;
    loads_sent++;
  endtask

  // shade one pixel; an entry never loaded gets a texel first
  task automatic shade_pixel(int col, int row);
    int entry;
    pixel_t want;
    longint w;
    entry = floor_entry(col, row);
    if (entry >= 0 && !texel_loaded[entry]) load_texel(entry, $urandom);
    w = (scr_w == 0) ? 1 : longint'(scr_w);
    want.addr    = ADDR_W'(longint'(row) * w + longint'(col));
    want.horizon = (entry < 0);
    want.color   = (entry < 0) ? '0 : texels[entry];
    push_item(KIND_SHADE, col, row, $urandom, $urandom);
    pending_pixels.push_back(want);
    shades_sent++;
  endtask

  task automatic drain_pixels();
    s_tvalid = 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
  endtask

  // register write, only with the pipe empty
  task automatic write_reg(cfg_reg_t idx, int value);
    drain_pixels();
    repeat (SETTLE) @(negedge clk);
    cfg_index = idx;
    cfg_data  = value[CFG_DATA_W-1:0];
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    case (idx)
      REG_SCREEN_WIDTH:  scr_w   = value[DIM_W-1:0];
      REG_SCREEN_HEIGHT: scr_h   = value[DIM_W-1:0];
      REG_CAM_POS_X:     pos_x   = value[POS_W-1:0];
      REG_CAM_POS_Y:     pos_y   = value[POS_W-1:0];
      REG_VIEW_DIR_X:    dir_x   = value[VEC_W-1:0];
      REG_VIEW_DIR_Y:    dir_y   = value[VEC_W-1:0];
      REG_CAM_PLANE_X:   plane_x = value[VEC_W-1:0];
      default:           plane_y = value[VEC_W-1:0];
    endcase
  endtask

  task automatic set_camera(int w, int h, int px, int py, int dx, int dy, int qx, int qy);
    write_reg(REG_SCREEN_WIDTH, w);
    write_reg(REG_SCREEN_HEIGHT, h);
    write_reg(REG_CAM_POS_X, px);
    write_reg(REG_CAM_POS_Y, py);
    write_reg(REG_VIEW_DIR_X, dx);
    write_reg(REG_VIEW_DIR_Y, dy);
    write_reg(REG_CAM_PLANE_X, qx);
    write_reg(REG_CAM_PLANE_Y, qy);
  endtask

  // field extremes, horizon, ceiling mirror, saturation, off-screen pixels
  task automatic test_directed();
    stall_pct = 0;
    load_texel(0, 0);
    load_texel(4095, 24'hFFFFFF);
    load_texel(12'hAAA, 24'h555555);
    shade_pixel(0, 479);
    shade_pixel(639, 479);
    shade_pixel(320, 240);         // horizon row
    shade_pixel(320, 100);         // above the horizon
    shade_pixel(2047, 2047);       // beyond the screen
    shade_pixel(0, 0);
    shade_pixel(1234, 241);
    set_camera(0, 2048, 24'hFFFFFF, 24'hFFFFFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
    shade_pixel(0, 1025);          // distance saturates high
    shade_pixel(2047, 1023);       // distance saturates low
    shade_pixel(5, 1024);          // horizon with width zero
    shade_pixel(2047, 0);
    set_camera(2048, 2, 0, 0, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
    shade_pixel(2047, 1);
    shade_pixel(0, 0);
    shade_pixel(1000, 2047);
    set_camera(1, 3, 24'h123456, 24'hABCDEF, 0, 0, 0, 0);
    shade_pixel(0, 1);
    shade_pixel(0, 2);
  endtask

  // random loads and shades under a random camera
  task automatic test_random_view(int items, int pct);
    int w, h, col, row, pick;
    w = ($urandom_range(9) == 0) ? $urandom_range(0, 2048) : $urandom_range(1, 800);
    h = ($urandom_range(9) == 0) ? $urandom_range(0, 2048) : $urandom_range(2, 600);
    set_camera(w, h, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    stall_pct = pct;
    for (int i = 0; i < items; i++) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        load_texel($urandom, $urandom);
      end else begin
        col = (pick < 25) ? $urandom_range(2047) : $urandom_range(0, (w > 0) ? w - 1 : 0);
        if (pick < 30)      row = h >> 1;
        else if (pick < 40) row = $urandom_range(2047);
        else                row = $urandom_range(0, (h > 0) ? h - 1 : 0);
        shade_pixel(col, row);
      end
    end
  endtask

  // output held off for a long stretch while the input keeps coming
  task automatic test_output_hold();
    stall_pct = 20;
    hold_req  = 400;
    for (int i = 0; i < 200; i++) shade_pixel($urandom_range(639), $urandom_range(479));
  endtask

  // input paused until every pixel has come back, then resumed
  task automatic test_input_pause();
    stall_pct = 50;
    for (int i = 0; i < 60; i++) shade_pixel($urandom_range(2047), $urandom_range(2047));
    drain_pixels();
    for (int i = 0; i < 60; i++) shade_pixel($urandom_range(2047), $urandom_range(2047));
  endtask

  initial begin
    errors = 0; cycles = 0; shades_sent = 0; loads_sent = 0;
    pixels_checked = 0; horizons_seen = 0; burst_left = 0;
    stall_pct = 0; hold_req = 0;
    s_tvalid = 1'b0; s_tdata = '0; s_tuser = KIND_LOAD;
    cfg_valid = 1'b0; cfg_index = REG_SCREEN_WIDTH; cfg_data = '0;
    m_tready = 1'b0;
    scr_w = SCREEN_WIDTH_RST; scr_h = SCREEN_HEIGHT_RST;
    pos_x = '0; pos_y = '0;
    dir_x = VIEW_DIR_X_RST; dir_y = '0; plane_x = '0; plane_y = CAM_PLANE_Y_RST;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      texels[i] = '0;
      texel_loaded[i] = 1'b0;
    end
    rst = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_output_hold();
    test_input_pause();
    // random views with stall rates from none to heavy; texels first hit
    // by a shade add loads of their own on top of these counts
    test_random_view(150, 0);
    test_random_view(150, 30);
    test_random_view(150, 60);
    test_random_view(150, 10);
    test_random_view(100, 45);
    test_random_view(100, 5);

    drain_pixels();
    repeat (SETTLE) @(posedge clk);
    $display("covered %0d shades and %0d texel loads, %0d pixels checked, %0d on the horizon",
             shades_sent, loads_sent, pixels_checked, horizons_seen);
    $display("register extremes, long output hold and full drain exercised, %0d mismatches",
             errors);
    if (errors == 0 && pending_pixels.size() == 0) begin
      $display("[floor_texture_caster_unit] OK");
    end else begin
      $display("[floor_texture_caster_unit] ERROR");
    end
    $finish;
  end

endmodule
